>>> hw/rtl/bb5_pkg.sv
package bb5_pkg;

    localparam int MAX_WIDTH_DEF = 1024;
    localparam int MAX_HEIGHT    = 4096;
    localparam int KERNEL_SIZE   = 5;
    localparam int HALF          = KERNEL_SIZE / 2;
    localparam int LB_ROWS       = KERNEL_SIZE - 1;

    localparam int NUM_CH = 3;
    localparam int CH_W   = 8;
    localparam int PIX_W  = NUM_CH * CH_W;

    // register fields as written on the config port
    localparam int WIDTH_REG_W  = 11;
    localparam int HEIGHT_REG_W = 13;
    localparam int CFG_DATA_W   = 13;
    localparam int CFG_IDX_W    = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

    localparam int W_RESET_DEF = 640;
    localparam int H_RESET     = 480;

    // row counter also covers the flush rows below the frame
    localparam int ROW_W    = 13;
    localparam int QROW_W   = $clog2(MAX_HEIGHT);
    localparam int HEIGHT_W = $clog2(MAX_HEIGHT + 1);

    localparam int CS_W  = $clog2(KERNEL_SIZE * 255 + 1);
    localparam int SUM_W = $clog2(KERNEL_SIZE * KERNEL_SIZE * 255 + 1);

    // floor(x / 25) == (x * DIV_MUL) >> DIV_SHIFT for every window sum
    localparam int DIV_SHIFT = 17;
    localparam int DIV_MUL   = (2 ** DIV_SHIFT) / (KERNEL_SIZE * KERNEL_SIZE) + 1;
    localparam int MUL_W     = $clog2(DIV_MUL + 1);
    localparam int PROD_W    = SUM_W + MUL_W;

    typedef struct packed {
        logic [PIX_W-1:0]       pix;
        logic [LB_ROWS-1:0]     vmask;  // bit j: row r-1-j lies at or below the first row of the frame
        logic [KERNEL_SIZE-1:0] hmask;  // bit s: column cc+HALF-s lies inside the row
        logic                   emit;
        logic                   last;
    } t_s0;

    typedef struct packed {
        logic [NUM_CH-1:0][CS_W-1:0] cs;
        logic [KERNEL_SIZE-1:0]      hmask;
        logic                        emit;
        logic                        last;
    } t_s2;

    typedef struct packed {
        logic [NUM_CH-1:0][CH_W-1:0] rgb;
        logic                        last;
    } t_result;

endpackage

>>> hw/rtl/bb5_ram.sv
module bb5_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // read returns the old word when both ports hit the same address
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> hw/rtl/bb5_ctrl.sv
module bb5_ctrl
    import bb5_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]        i_cfg_data,
    input  logic                         i_en,
    input  logic                         i_in_valid,
    input  logic [PIX_W-1:0]             i_in_pix,
    input  logic                         i_in_flush,
    output logic                         o_s0_valid,
    output logic [$clog2(MAX_WIDTH)-1:0] o_s0_col,
    output t_s0                          o_s0
);

    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int W_W     = $clog2(MAX_WIDTH + 1);
    localparam int LAG_W   = $clog2(2 * MAX_WIDTH + 3);
    localparam int W_RESET = (W_RESET_DEF > MAX_WIDTH) ? MAX_WIDTH : W_RESET_DEF;

    logic [W_W-1:0]      r_w, cfg_w;
    logic [HEIGHT_W-1:0] r_h, cfg_h;
    logic [COL_W-1:0]    r_col, n_col, r_qc, n_qc;
    logic [ROW_W-1:0]    r_row, n_row;
    logic [QROW_W-1:0]   r_qr, n_qr;
    logic [LAG_W-1:0]    r_lag, n_lag, delay;
    logic                take, col_wrap, qc_wrap, emit, last;
    logic                r_s0_valid;
    logic [COL_W-1:0]    r_s0_col;
    t_s0                 r_s0, n_s0;

    always_comb begin : cfg_clamp
        logic [WIDTH_REG_W-1:0]  wv;
        logic [HEIGHT_REG_W-1:0] hv;
        wv = i_cfg_data[WIDTH_REG_W-1:0];
        hv = i_cfg_data[HEIGHT_REG_W-1:0];
        if (wv == '0) begin
            cfg_w = W_W'(1);
        end else if (int'(wv) > MAX_WIDTH) begin
            cfg_w = W_W'(MAX_WIDTH);
        end else begin
            cfg_w = W_W'(wv);
        end
        if (hv == '0) begin
            cfg_h = HEIGHT_W'(1);
        end else if (int'(hv) > MAX_HEIGHT) begin
            cfg_h = HEIGHT_W'(MAX_HEIGHT);
        end else begin
            cfg_h = HEIGHT_W'(hv);
        end
    end

    always_comb begin : pos_logic
        int dx;
        delay    = LAG_W'({r_w, 1'b0}) + LAG_W'(2);
        // a flush with no frame in progress is taken off the bus and dropped
        take     = i_in_valid && i_en && !((r_lag == '0) && i_in_flush);
        col_wrap = (W_W'(r_col) + W_W'(1)) == r_w;
        qc_wrap  = (W_W'(r_qc) + W_W'(1)) == r_w;
        emit     = (r_lag == delay);
        last     = emit && qc_wrap && ((HEIGHT_W'(r_qr) + HEIGHT_W'(1)) == r_h);

        n_col = col_wrap ? '0 : r_col + COL_W'(1);
        n_row = col_wrap ? r_row + ROW_W'(1) : r_row;
        n_lag = emit ? r_lag : r_lag + LAG_W'(1);
        n_qc  = r_qc;
        n_qr  = r_qr;
        if (emit) begin
            n_qc = qc_wrap ? '0 : r_qc + COL_W'(1);
            n_qr = qc_wrap ? r_qr + QROW_W'(1) : r_qr;
        end
        if (last) begin
            n_col = '0;
            n_row = '0;
            n_lag = '0;
            n_qc  = '0;
            n_qr  = '0;
        end

        n_s0.pix  = ((r_row < ROW_W'(r_h)) && !i_in_flush) ? i_in_pix : '0;
        n_s0.emit = emit;
        n_s0.last = last;
        for (int j = 0; j < LB_ROWS; j++) begin
            n_s0.vmask[j] = r_row >= ROW_W'(j + 1);
        end
        for (int s = 0; s < KERNEL_SIZE; s++) begin
            dx = HALF - s;
            if (dx >= 0) begin
                n_s0.hmask[s] = (W_W+1)'(r_qc) + (W_W+1)'(dx + 1) <= (W_W+1)'(r_w);
            end else begin
                n_s0.hmask[s] = r_qc >= COL_W'(-dx);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w        <= W_W'(W_RESET);
            r_h        <= HEIGHT_W'(H_RESET);
            r_col      <= '0;
            r_row      <= '0;
            r_lag      <= '0;
            r_qc       <= '0;
            r_qr       <= '0;
            r_s0_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                unique case (i_cfg_idx)
                    CFG_IMAGE_WIDTH:  r_w <= cfg_w;
                    CFG_IMAGE_HEIGHT: r_h <= cfg_h;
                endcase
                // any register write restarts the frame
                r_col <= '0;
                r_row <= '0;
                r_lag <= '0;
                r_qc  <= '0;
                r_qr  <= '0;
            end else if (take) begin
                r_col <= n_col;
                r_row <= n_row;
                r_lag <= n_lag;
                r_qc  <= n_qc;
                r_qr  <= n_qr;
            end
            if (i_en) begin
                r_s0_valid <= take;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_s0     <= n_s0;
            r_s0_col <= r_col;
        end
    end

    assign o_s0_valid = r_s0_valid;
    assign o_s0_col   = r_s0_col;
    assign o_s0       = r_s0;

    a_col_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        W_W'(r_col) < r_w)
        else $error("input column beyond image width");

    a_lag_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lag <= delay)
        else $error("startup lag counter ran past the window delay");

    a_center_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        HEIGHT_W'(r_qr) < r_h)
        else $error("output center row beyond image height");

endmodule

>>> hw/rtl/bb5_line.sv
module bb5_line
    import bb5_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_s0_valid,
    input  logic [$clog2(MAX_WIDTH)-1:0] i_s0_col,
    input  t_s0                          i_s0,
    output logic                         o_s2_valid,
    output t_s2                          o_s2
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int LB_W  = LB_ROWS * PIX_W;

    logic [LB_W-1:0]  ram_rd, rows, wr_data, r_fwd_data;
    logic             r_fwd;
    logic             r_s1_valid, r_s2_valid;
    logic [COL_W-1:0] r_s1_col;
    t_s0              r_s1;
    t_s2              n_s2, r_s2;

    // one word per column: the four rows above the incoming pixel
    bb5_ram #(
        .WIDTH (LB_W),
        .DEPTH (MAX_WIDTH)
    ) u_lines (
        .i_clk     (i_clk),
        .i_wr_en   (i_en && r_s1_valid),
        .i_wr_addr (r_s1_col),
        .i_wr_data (wr_data),
        .i_rd_en   (i_en && i_s0_valid),
        .i_rd_addr (i_s0_col),
        .o_rd_data (ram_rd)
    );

    always_comb begin : col_sum
        logic [CS_W-1:0] acc;
        rows    = r_fwd ? r_fwd_data : ram_rd;
        // push the new pixel in at the top, drop the oldest row
        wr_data = {rows[LB_W-PIX_W-1:0], r_s1.pix};
        for (int ch = 0; ch < NUM_CH; ch++) begin
            acc = CS_W'(r_s1.pix[ch*CH_W +: CH_W]);
            for (int j = 0; j < LB_ROWS; j++) begin
                if (r_s1.vmask[j]) begin
                    acc = acc + CS_W'(rows[j*PIX_W + ch*CH_W +: CH_W]);
                end
            end
            n_s2.cs[ch] = acc;
        end
        n_s2.hmask = r_s1.hmask;
        n_s2.emit  = r_s1.emit;
        n_s2.last  = r_s1.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_fwd      <= 1'b0;
        end else if (i_en) begin
            r_s1_valid <= i_s0_valid;
            r_s2_valid <= r_s1_valid;
            // back-to-back beats on one column: the read missed this write
            r_fwd      <= i_s0_valid && r_s1_valid && (i_s0_col == r_s1_col);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_fwd_data <= wr_data;
            if (i_s0_valid) begin
                r_s1     <= i_s0;
                r_s1_col <= i_s0_col;
            end
            if (r_s1_valid) begin
                r_s2 <= n_s2;
            end
        end
    end

    assign o_s2_valid = r_s2_valid;
    assign o_s2       = r_s2;

    a_fwd_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd |-> r_s1_valid)
        else $error("forwarded line data without an item in stage 1");

endmodule

>>> hw/rtl/bb5_sum.sv
module bb5_sum
    import bb5_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_en,
    input  logic    i_s2_valid,
    input  t_s2     i_s2,
    output logic    o_res_valid,
    output t_result o_res
);

    logic [NUM_CH-1:0][CS_W-1:0]   r_hist [KERNEL_SIZE-1];
    logic [NUM_CH-1:0][SUM_W-1:0]  n_sum, r_s3_sum;
    logic [NUM_CH-1:0][PROD_W-1:0] prod;
    logic                          r_s3_valid, r_s3_last;

    // slot 0 is the newest column sum, slot s the one s beats older
    always_comb begin : row_sum
        logic [SUM_W-1:0] acc;
        for (int ch = 0; ch < NUM_CH; ch++) begin
            acc = i_s2.hmask[0] ? SUM_W'(i_s2.cs[ch]) : '0;
            for (int s = 1; s < KERNEL_SIZE; s++) begin
                if (i_s2.hmask[s]) begin
                    acc = acc + SUM_W'(r_hist[s-1][ch]);
                end
            end
            n_sum[ch] = acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (i_en) begin
            r_s3_valid <= i_s2_valid && i_s2.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && i_s2_valid) begin
            r_hist[0] <= i_s2.cs;
            for (int k = 1; k < KERNEL_SIZE - 1; k++) begin
                r_hist[k] <= r_hist[k-1];
            end
            if (i_s2.emit) begin
                r_s3_sum  <= n_sum;
                r_s3_last <= i_s2.last;
            end
        end
    end

    // divide by the window area through a reciprocal multiply
    always_comb begin
        for (int ch = 0; ch < NUM_CH; ch++) begin
            prod[ch]      = PROD_W'(r_s3_sum[ch]) * PROD_W'(DIV_MUL);
            o_res.rgb[ch] = prod[ch][DIV_SHIFT +: CH_W];
        end
        o_res.last = r_s3_last;
    end

    assign o_res_valid = r_s3_valid;

endmodule

>>> hw/rtl/rgb_box_blur_5x5_core.sv
// A result beat goes through stage 0 (ctrl), stages 1 and 2 (line), stage 3 (sum) and the
// output register; its window is complete 2*width+2 beats after its own center pixel.
// Throughput: one beat per cycle unless the skid slot is full (line buffer RAM: one read, one write a cycle).
// Reset (synchronous, active low): counters and valids clear, width 640 (at most
// MAX_WIDTH) and height 480; line buffer RAM is not cleared, rows above the frame are masked.
module rgb_box_blur_5x5_core
    import bb5_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [PIX_W-1:0]      s_axis_tdata,   // pixel_red, pixel_green, pixel_blue
    input  logic [0:0]            s_axis_tuser,   // flush_item
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [PIX_W-1:0]      m_axis_tdata,   // blurred_red, blurred_green, blurred_blue
    output logic                  m_axis_tlast
);

    localparam int COL_W = $clog2(MAX_WIDTH);

    logic             en;
    logic             s0_valid, s2_valid, res_valid;
    logic [COL_W-1:0] s0_col;
    t_s0              s0;
    t_s2              s2;
    t_result          res, r_out, r_skid;
    logic             r_out_valid, r_skid_valid;

    // the pipeline holds only while the skid slot is occupied
    assign en            = !r_skid_valid;
    assign s_axis_tready = en;

    bb5_ctrl #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_en        (en),
        .i_in_valid  (s_axis_tvalid),
        .i_in_pix    (s_axis_tdata),
        .i_in_flush  (s_axis_tuser[0]),
        .o_s0_valid  (s0_valid),
        .o_s0_col    (s0_col),
        .o_s0        (s0)
    );

    bb5_line #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_s0_valid (s0_valid),
        .i_s0_col   (s0_col),
        .i_s0       (s0),
        .o_s2_valid (s2_valid),
        .o_s2       (s2)
    );

    bb5_sum u_sum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_s2_valid  (s2_valid),
        .i_s2        (s2),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (m_axis_tready) begin
                r_skid_valid <= 1'b0;
            end
        end else if (res_valid) begin
            if (!r_out_valid || m_axis_tready) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (m_axis_tready) begin
                r_out <= r_skid;
            end
        end else if (res_valid) begin
            if (!r_out_valid || m_axis_tready) begin
                r_out <= res;
            end else begin
                r_skid <= res;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out.rgb;
    assign m_axis_tlast  = r_out.last;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid slot holds a beat while the output register is empty");

    a_skid_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(m_axis_tvalid && !m_axis_tready))
        else $error("skid slot filled without an output stall");

endmodule

>>> tb/bb5_blur_checker.sv
module bb5_blur_checker
    import bb5_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    input  logic [PIX_W-1:0]      i_s_tdata,    // pixel_red, pixel_green, pixel_blue
    input  logic [0:0]            i_s_tuser,    // flush_item
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    input  logic [PIX_W-1:0]      i_m_tdata,    // blurred_red, blurred_green, blurred_blue
    input  logic                  i_m_tlast,
    output int                    o_mismatches,
    output int                    o_outstanding,
    output int                    o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    // enough history for the newest pixel plus everything back to the top-left of its window
    localparam int RING_DEPTH = 2 * (HALF * MAX_WIDTH_DEF + HALF) + 1;
    localparam int KAREA      = KERNEL_SIZE * KERNEL_SIZE;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic            last;
    } blur_px_t;

    logic [PIX_W-1:0]        pix_hist [RING_DEPTH];
    logic [WIDTH_REG_W-1:0]  width_reg;
    logic [HEIGHT_REG_W-1:0] height_reg;
    int                      col_pos;
    int                      row_pos;
    blur_px_t                blur_q[$];
    int                      mism = 0;
    int                      chk  = 0;

    initial begin
        o_mismatches  = 0;
        o_outstanding = 0;
        o_checked     = 0;
    end

    // Take one accepted input beat and queue the blurred pixel it completes, if any.
    task automatic advance_window(input logic [PIX_W-1:0] px, input logic flush);
        int       w, h, total, p, delay, q, cr, cc, nr, nc, dy, dx;
        int       sr, sg, sb;
        logic [PIX_W-1:0] v;
        blur_px_t res;
        w = (width_reg == '0) ? 1 :
            (width_reg > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : int'(width_reg);
        h = (height_reg == '0) ? 1 :
            (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : int'(height_reg);
        total = w * h;
        p     = row_pos * w + col_pos;
        delay = HALF * w + HALF;
        // drop a flush when no frame is under way
        if (p == 0 && flush) return;
        pix_hist[p % RING_DEPTH] = (p < total && !flush) ? px : '0;
        col_pos++;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
        end
        if (p < delay) return;
        q = p - delay;
        if (q >= total) begin
            col_pos = 0;
            row_pos = 0;
            return;
        end
        cr = q / w;
        cc = q % w;
        sr = 0;
        sg = 0;
        sb = 0;
        for (dy = -HALF; dy <= HALF; dy++) begin
            nr = cr + dy;
            if (nr < 0 || nr >= h) continue;
            for (dx = -HALF; dx <= HALF; dx++) begin
                nc = cc + dx;
                if (nc < 0 || nc >= w) continue;
                v = pix_hist[(nr * w + nc) % RING_DEPTH];
                sr += v[CH_W-1:0];
                sg += v[2*CH_W-1:CH_W];
                sb += v[3*CH_W-1:2*CH_W];
            end
        end
        res.red   = CH_W'(sr / KAREA);
        res.green = CH_W'(sg / KAREA);
        res.blue  = CH_W'(sb / KAREA);
        res.last  = (q == total - 1);
        if (res.last) begin
            col_pos = 0;
            row_pos = 0;
        end
        blur_q.push_back(res);
    endtask

    always @(posedge i_clk) begin : monitor
        blur_px_t got;
        blur_px_t want;
        int       k;
        if (!i_rst_n) begin
            for (k = 0; k < RING_DEPTH; k++) pix_hist[k] = '0;
            col_pos    = 0;
            row_pos    = 0;
            width_reg  = WIDTH_REG_W'(W_RESET_DEF);
            height_reg = HEIGHT_REG_W'(H_RESET);
            blur_q.delete();
        end else begin
            if (i_cfg_wr_en) begin
                if (i_cfg_idx == CFG_IMAGE_WIDTH)
                    width_reg = i_cfg_data[WIDTH_REG_W-1:0];
                else if (i_cfg_idx == CFG_IMAGE_HEIGHT)
                    height_reg = i_cfg_data[HEIGHT_REG_W-1:0];
                // any write restarts the frame
                col_pos = 0;
                row_pos = 0;
            end
            if (i_s_tvalid && i_s_tready)
                advance_window(i_s_tdata, i_s_tuser[0]);
            if (i_m_tvalid && i_m_tready) begin
                got.red   = i_m_tdata[CH_W-1:0];
                got.green = i_m_tdata[2*CH_W-1:CH_W];
                got.blue  = i_m_tdata[3*CH_W-1:2*CH_W];
                got.last  = i_m_tlast;
                if (blur_q.size() == 0) begin
                    $error("unexpected output beat: r %0d g %0d b %0d last %0b",
                           got.red, got.green, got.blue, got.last);
                    mism++;
                end else begin
                    want = blur_q.pop_front();
                    chk++;
                    if (got.red !== want.red) begin
                        $error("blurred_red: expected %0d, got %0d", want.red, got.red);
                        mism++;
                    end
                    if (got.green !== want.green) begin
                        $error("blurred_green: expected %0d, got %0d", want.green, got.green);
                        mism++;
                    end
                    if (got.blue !== want.blue) begin
                        $error("blurred_blue: expected %0d, got %0d", want.blue, got.blue);
                        mism++;
                    end
                    if (got.last !== want.last) begin
                        $error("frame_last: expected %0b, got %0b", want.last, got.last);
                        mism++;
                    end
                end
            end
        end
        o_outstanding <= blur_q.size();
        o_mismatches  <= mism;
        o_checked     <= chk;
    end

endmodule

>>> tb/tb_rgb_box_blur_5x5_core.sv
module tb_rgb_box_blur_5x5_core;
    timeunit 1ns;
    timeprecision 1ps;
    import bb5_pkg::*;

    typedef enum int {FILL_RANDOM, FILL_WHITE, FILL_BLACK, FILL_EXTREME} fill_t;

    localparam int HOLD_CYCLES = 400;
    localparam int RAND_ITEMS  = 750;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  cfg_wr_en  = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx    = CFG_IMAGE_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_data   = '0;
    logic                  s_tvalid   = 1'b0;
    logic                  s_tready;
    logic [PIX_W-1:0]      s_tdata    = '0;
    logic [0:0]            s_tuser    = '0;
    logic                  m_tvalid;
    logic                  m_tready   = 1'b0;
    logic [PIX_W-1:0]      m_tdata;
    logic                  m_tlast;

    int mismatches;
    int outstanding;
    int checked;

    bit src_idle_en = 1'b1;
    bit snk_idle_en = 1'b1;
    bit rx_hold_req = 1'b0;

    logic [WIDTH_REG_W-1:0]  cur_w_reg = WIDTH_REG_W'(W_RESET_DEF);
    logic [HEIGHT_REG_W-1:0] cur_h_reg = HEIGHT_REG_W'(H_RESET);
    int items_sent  = 0;
    int frames_sent = 0;
    int cfg_writes  = 0;

    always #1 i_clk = ~i_clk;

    rgb_box_blur_5x5_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tlast  (m_tlast)
    );

    bb5_blur_checker u_chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .i_s_tvalid    (s_tvalid),
        .i_s_tready    (s_tready),
        .i_s_tdata     (s_tdata),
        .i_s_tuser     (s_tuser),
        .i_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .i_m_tdata     (m_tdata),
        .i_m_tlast     (m_tlast),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding),
        .o_checked     (checked)
    );

    // Offer one beat and hold it until accepted, then maybe idle for a burst.
    task automatic push_beat(input logic [PIX_W-1:0] data, input logic flush);
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= flush;
        do @(posedge i_clk); while (!s_tready);
        items_sent++;
        if (src_idle_en && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
    endtask

    // Wait for every predicted beat, then let the pipeline settle.
    task automatic drain_idle();
        s_tvalid <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_idx   <= idx;
        cfg_data  <= data;
        @(posedge i_clk);
        cfg_writes++;
    endtask

    task automatic configure(input bit set_w, input logic [CFG_DATA_W-1:0] wdata,
                             input bit set_h, input logic [CFG_DATA_W-1:0] hdata);
        drain_idle();
        if (set_w) begin
            write_reg(CFG_IMAGE_WIDTH, wdata);
            cur_w_reg = wdata[WIDTH_REG_W-1:0];
        end
        if (set_h) begin
            write_reg(CFG_IMAGE_HEIGHT, hdata);
            cur_h_reg = hdata[HEIGHT_REG_W-1:0];
        end
        cfg_wr_en <= 1'b0;
    endtask

    // One frame: optional ignored flushes, the pixels, then flush or junk beats until the
    // last centre comes out. A nonzero cut stops the frame early after that many beats.
    task automatic send_frame(input int lead, input int flush_pct, input int junk_pct,
                              input fill_t fill, input int cut);
        int               w, h, total, n, i, p;
        logic [PIX_W-1:0] px;
        logic             fl;
        w = (cur_w_reg == '0) ? 1 :
            (cur_w_reg > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : int'(cur_w_reg);
        h = (cur_h_reg == '0) ? 1 :
            (cur_h_reg > MAX_HEIGHT) ? MAX_HEIGHT : int'(cur_h_reg);
        total = w * h;
        n = (cut > 0) ? cut : total + HALF * w + HALF;
        for (i = 0; i < lead; i++) push_beat(PIX_W'($urandom), 1'b1);
        for (p = 0; p < n; p++) begin
            case (fill)
                FILL_WHITE: px = '1;
                FILL_BLACK: px = '0;
                FILL_EXTREME: px = {{CH_W{1'($urandom_range(0, 1))}},
                                    {CH_W{1'($urandom_range(0, 1))}},
                                    {CH_W{1'($urandom_range(0, 1))}}};
                default: px = PIX_W'($urandom);
            endcase
            if (p < total)
                fl = (p != 0) && ($urandom_range(0, 99) < flush_pct);
            else
                fl = !($urandom_range(0, 99) < junk_pct);
            push_beat(px, fl);
        end
        frames_sent++;
    endtask

    initial begin : sink
        int n;
        bit hold_done;
        hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_req && !hold_done) begin
                // long hold so the block backs up into its input
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                m_tready <= 1'b1;
            end else if (snk_idle_en && $urandom_range(0, 7) == 0) begin
                m_tready <= 1'b0;
                n = $urandom_range(1, 18);
                repeat (n) @(posedge i_clk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        #5_000_000;
        $display("tb_rgb_box_blur_5x5_core: FAIL");
        $finish;
    end

    initial begin : stim
        int    rand_start, w, h, total, cut, wait_cnt, mode;
        bit    need_cfg;
        fill_t fill;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset geometry: the start of a 640-wide frame, too short to reach a centre
        send_frame(2, 0, 0, FILL_RANDOM, 40);

        configure(1'b1, 13'd1, 1'b1, 13'd1);
        send_frame(1, 0, 0, FILL_WHITE, 0);
        configure(1'b1, 13'd0, 1'b1, 13'd0);
        send_frame(0, 0, 0, FILL_RANDOM, 0);
        configure(1'b1, 13'd5, 1'b1, 13'd5);
        send_frame(0, 0, 0, FILL_WHITE, 0);
        send_frame(1, 0, 0, FILL_BLACK, 0);
        configure(1'b1, 13'd3, 1'b1, 13'd2);
        send_frame(0, 50, 50, FILL_EXTREME, 0);

        // out-of-range register values clamp to the maximum; keep these frames short
        configure(1'b1, 13'h1FFF, 1'b1, 13'd1);
        send_frame(0, 5, 5, FILL_EXTREME, 48);
        configure(1'b1, 13'd1, 1'b1, 13'h1FFF);
        send_frame(0, 5, 5, FILL_RANDOM, 64);

        // back-pressure: source offers continuously while the sink holds off
        configure(1'b1, 13'd16, 1'b1, 13'd12);
        src_idle_en = 1'b0;
        rx_hold_req <= 1'b1;
        send_frame(0, 0, 0, FILL_RANDOM, 0);
        src_idle_en = 1'b1;

        need_cfg   = 1'b1;
        rand_start = items_sent;
        for (mode = 0; mode < 2; mode++) begin
            if (mode == 1) begin
                drain_idle();
                src_idle_en = 1'b0;
                snk_idle_en <= 1'b0;
                rand_start = items_sent;
            end
            while (items_sent - rand_start < ((mode == 0) ? RAND_ITEMS : 150)) begin
                if (need_cfg || $urandom_range(0, 9) < 7) begin
                    w = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 40)
                                                    : $urandom_range(1, 10);
                    h = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 30)
                                                    : $urandom_range(1, 12);
                    case ($urandom_range(0, 3))
                        0: configure(1'b1, {2'($urandom), 11'(w)}, 1'b0, '0);
                        1: configure(1'b0, '0, 1'b1, 13'(h));
                        default: configure(1'b1, {2'($urandom), 11'(w)}, 1'b1, 13'(h));
                    endcase
                end
                w = (cur_w_reg == '0) ? 1 :
                    (cur_w_reg > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : int'(cur_w_reg);
                h = (cur_h_reg == '0) ? 1 :
                    (cur_h_reg > MAX_HEIGHT) ? MAX_HEIGHT : int'(cur_h_reg);
                total = w * h;
                cut = (mode == 0 && $urandom_range(0, 9) == 0)
                    ? $urandom_range(1, total + HALF * w + HALF - 1) : 0;
                case ($urandom_range(0, 9))
                    0: fill = FILL_WHITE;
                    1: fill = FILL_BLACK;
                    2: fill = FILL_EXTREME;
                    default: fill = FILL_RANDOM;
                endcase
                send_frame(($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0,
                           ($urandom_range(0, 3) == 0) ? 20 : 0,
                           ($urandom_range(0, 3) == 0) ? 30 : 0,
                           fill, cut);
                need_cfg = (cut != 0);
            end
        end

        s_tvalid <= 1'b0;
        repeat (2) @(posedge i_clk);
        wait_cnt = 0;
        while (outstanding != 0 && wait_cnt < 200000) begin
            @(posedge i_clk);
            wait_cnt++;
        end
        repeat (20) @(posedge i_clk);
        if (outstanding != 0)
            $error("%0d predicted output beats never arrived", outstanding);

        $display("run covered %0d frames, %0d input beats and %0d register writes",
                 frames_sent, items_sent, cfg_writes);
        $display("%0d blurred beats compared, %0d field mismatches", checked, mismatches);
        if (mismatches == 0 && outstanding == 0) begin
            $display("tb_rgb_box_blur_5x5_core: PASS");
        end else begin
            $display("tb_rgb_box_blur_5x5_core: FAIL");
        end
        $finish;
    end

endmodule
